/* hw/rtl/mcsl_pkg.sv */
// ----------------------------------------------------------------------------
// mcsl_pkg: shared types and constants of the mecanum chassis speed loop
// Register indexes, reset values, stick bands, fixed-point scale factors and
// the control and configuration structs passed between the pipeline parts.
// ----------------------------------------------------------------------------
`default_nettype none

package mcsl_pkg;

	localparam int WheelCount = 4;

	// configuration port
	localparam int CfgIndexW = 3;
	localparam int CfgDataW  = 16;

	localparam logic [CfgIndexW-1:0] RegPropGain   = 3'd0;
	localparam logic [CfgIndexW-1:0] RegIntegGain  = 3'd1;
	localparam logic [CfgIndexW-1:0] RegDerivGain  = 3'd2;
	localparam logic [CfgIndexW-1:0] RegIntegLimit = 3'd3;
	localparam logic [CfgIndexW-1:0] RegSpinRate   = 3'd4;

	localparam logic [15:0] PropGainRst   = 16'd3840;
	localparam logic [15:0] IntegGainRst  = 16'd179;
	localparam logic [15:0] DerivGainRst  = 16'd768;
	localparam logic [14:0] IntegLimitRst = 15'd10000;
	localparam logic [11:0] SpinRateRst   = 12'd2040;

	// rotate switch codes
	localparam logic [1:0] SwSpinPos = 2'd1;
	localparam logic [1:0] SwSpinNeg = 2'd2;

	// stick bands and center
	localparam logic [10:0] StickCenter = 11'd1024;
	localparam logic [10:0] TurnLo      = 11'd364;
	localparam logic [10:0] TurnHi      = 11'd1684;
	localparam logic [10:0] StrafeLo    = 11'd364;
	localparam logic [10:0] StrafeHi    = 11'd1684;
	localparam logic [10:0] ForwardLo   = 11'd363;
	localparam logic [10:0] ForwardHi   = 11'd1685;

	// mag*2000/660 = mag*100/33, done as mag * (100*ceil(2^27/33)) >> 27,
	// exact for every offset inside the bands
	localparam int          StickShift = 27;
	localparam int          StickProdW = 38;
	localparam logic [28:0] StickScale = 29'd406720400;

	typedef logic signed [13:0] target_t;
	typedef logic signed [15:0] speed_t;

	// pipeline stage loads and the state update strobe
	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
		logic en4;
		logic en5;
		logic upd;
	} ctl_t;

	typedef struct packed {
		logic [15:0] prop_gain;
		logic [15:0] integ_gain;
		logic [15:0] deriv_gain;
		logic [14:0] integ_limit;
	} pid_cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/mcsl_in_if.sv */
// ----------------------------------------------------------------------------
// mcsl_in_if: input channel of the chassis speed loop
// One word per control tick: sticks, rotate switch and four wheel speeds.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcsl_in_if;
	logic        valid;
	logic        ready;
	logic [10:0] turn_stick;
	logic [10:0] strafe_stick;
	logic [10:0] forward_stick;
	logic [1:0]  rotate_switch;
	logic signed [15:0] speed_one;
	logic signed [15:0] speed_two;
	logic signed [15:0] speed_three;
	logic signed [15:0] speed_four;

	modport source (
		output valid, turn_stick, strafe_stick, forward_stick, rotate_switch,
		output speed_one, speed_two, speed_three, speed_four,
		input  ready
	);

	modport sink (
		input  valid, turn_stick, strafe_stick, forward_stick, rotate_switch,
		input  speed_one, speed_two, speed_three, speed_four,
		output ready
	);
endinterface

`default_nettype wire

/* hw/rtl/mcsl_out_if.sv */
// ----------------------------------------------------------------------------
// mcsl_out_if: output channel of the chassis speed loop
// One word per control tick: four saturated wheel drives.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcsl_out_if;
	logic valid;
	logic ready;
	logic signed [15:0] drive_one;
	logic signed [15:0] drive_two;
	logic signed [15:0] drive_three;
	logic signed [15:0] drive_four;

	modport source (
		output valid, drive_one, drive_two, drive_three, drive_four,
		input  ready
	);

	modport sink (
		input  valid, drive_one, drive_two, drive_three, drive_four,
		output ready
	);
endinterface

`default_nettype wire

/* hw/rtl/mcsl_mixer.sv */
// ----------------------------------------------------------------------------
// mcsl_mixer: stick scaling and mecanum mixing
// Stage 1 gates and scales the sticks, stage 2 forms the four wheel targets.
// ----------------------------------------------------------------------------
`default_nettype none

module mcsl_mixer (
	input  wire logic                 clk,
	input  wire mcsl_pkg::ctl_t       ctl,
	input  wire logic [11:0]          spin_rate,
	input  wire logic [10:0]          turn_stick,
	input  wire logic [10:0]          strafe_stick,
	input  wire logic [10:0]          forward_stick,
	input  wire logic [1:0]           rotate_switch,
	output mcsl_pkg::target_t         target [mcsl_pkg::WheelCount]
);

	localparam int QW = mcsl_pkg::StickProdW - mcsl_pkg::StickShift;

	logic                              str_neg, fwd_neg, str_ok, fwd_ok, turn_ok;
	logic [10:0]                       str_mag, fwd_mag;
	logic [mcsl_pkg::StickProdW-1:0]   str_prod, fwd_prod;
	logic signed [12:0]                spin;

	logic [mcsl_pkg::StickProdW-1:0]   str_prod_s1, fwd_prod_s1;
	logic                              str_neg_s1, fwd_neg_s1, str_ok_s1, fwd_ok_s1;
	logic signed [12:0]                spin_s1;

	logic [QW-1:0]                     str_q, fwd_q;
	logic signed [11:0]                str_val, fwd_val;
	logic signed [13:0]                str_x, fwd_x, spin_x;

	// offset from center, band check and scaled magnitude
	always_comb begin
		str_neg = strafe_stick < mcsl_pkg::StickCenter;
		fwd_neg = forward_stick < mcsl_pkg::StickCenter;
		str_mag = str_neg ? (mcsl_pkg::StickCenter - strafe_stick)
		                  : (strafe_stick - mcsl_pkg::StickCenter);
		fwd_mag = fwd_neg ? (mcsl_pkg::StickCenter - forward_stick)
		                  : (forward_stick - mcsl_pkg::StickCenter);
		str_ok  = (strafe_stick >= mcsl_pkg::StrafeLo) && (strafe_stick <= mcsl_pkg::StrafeHi);
		fwd_ok  = (forward_stick >= mcsl_pkg::ForwardLo)
		       && (forward_stick <= mcsl_pkg::ForwardHi);
		turn_ok = (turn_stick >= mcsl_pkg::TurnLo) && (turn_stick <= mcsl_pkg::TurnHi);
		str_prod = mcsl_pkg::StickProdW'(str_mag[9:0])
		         * mcsl_pkg::StickProdW'(mcsl_pkg::StickScale);
		fwd_prod = mcsl_pkg::StickProdW'(fwd_mag[9:0])
		         * mcsl_pkg::StickProdW'(mcsl_pkg::StickScale);
	end

	// spin from the switch, dropped when the turn stick is off band
	always_comb begin
		spin = '0;
		case (rotate_switch)
			mcsl_pkg::SwSpinPos: spin = $signed({1'b0, spin_rate});
			mcsl_pkg::SwSpinNeg: spin = -$signed({1'b0, spin_rate});
			default:             spin = '0;
		endcase
		if (!turn_ok)
			spin = '0;
	end

	// stage 1 registers
	always_ff @(posedge clk) begin
		if (ctl.en1) begin
			str_prod_s1 <= str_prod;
			fwd_prod_s1 <= fwd_prod;
			str_neg_s1  <= str_neg;
			fwd_neg_s1  <= fwd_neg;
			str_ok_s1   <= str_ok;
			fwd_ok_s1   <= fwd_ok;
			spin_s1     <= spin;
		end
	end

	// quotient, sign and gate
	always_comb begin
		str_q   = str_prod_s1[mcsl_pkg::StickProdW-1:mcsl_pkg::StickShift];
		fwd_q   = fwd_prod_s1[mcsl_pkg::StickProdW-1:mcsl_pkg::StickShift];
		str_val = str_neg_s1 ? -$signed({1'b0, str_q}) : $signed({1'b0, str_q});
		fwd_val = fwd_neg_s1 ? -$signed({1'b0, fwd_q}) : $signed({1'b0, fwd_q});
		if (!str_ok_s1)
			str_val = '0;
		if (!fwd_ok_s1)
			fwd_val = '0;
		str_x  = {{2{str_val[11]}}, str_val};
		fwd_x  = {{2{fwd_val[11]}}, fwd_val};
		spin_x = {spin_s1[12], spin_s1};
	end

	// stage 2: mecanum mix
	always_ff @(posedge clk) begin
		if (ctl.en2) begin
			target[0] <=  str_x + fwd_x + spin_x;
			target[1] <=  str_x - fwd_x + spin_x;
			target[2] <= -str_x + fwd_x + spin_x;
			target[3] <= -str_x - fwd_x + spin_x;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/mcsl_pid_lane.sv */
// ----------------------------------------------------------------------------
// mcsl_pid_lane: speed PID of one wheel
// Error and state update, three gain products, then sum, scale and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module mcsl_pid_lane (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mcsl_pkg::ctl_t      ctl,
	input  wire mcsl_pkg::pid_cfg_t  cfg,
	input  wire mcsl_pkg::speed_t    speed,
	input  wire mcsl_pkg::target_t   target,
	output logic signed [15:0]       drive
);

	mcsl_pkg::speed_t     speed_s1, speed_s2;
	logic signed [16:0]   prev_err_q;
	logic signed [15:0]   err_sum_q;

	logic signed [16:0]   err;
	logic signed [17:0]   err_diff;
	logic signed [17:0]   sum_next;
	logic signed [17:0]   lim;

	logic signed [16:0]   err_s3;
	logic signed [17:0]   diff_s3;
	logic signed [15:0]   sum_s3;

	logic signed [33:0]   p_s4;
	logic signed [34:0]   d_s4;
	logic signed [32:0]   i_s4;

	logic signed [36:0]   acc;
	logic signed [36:0]   acc_bias;
	logic signed [36:0]   quo;

	// carry the measured speed alongside the mixer
	always_ff @(posedge clk) begin
		if (ctl.en1)
			speed_s1 <= speed;
		if (ctl.en2)
			speed_s2 <= speed_s1;
	end

	// error, difference and clamped running sum
	always_comb begin
		err      = {{3{target[13]}}, target} - {speed_s2[15], speed_s2};
		err_diff = {err[16], err} - {prev_err_q[16], prev_err_q};
		lim      = $signed({3'd0, cfg.integ_limit});
		sum_next = {{2{err_sum_q[15]}}, err_sum_q} + {err[16], err};
		if (sum_next > lim)
			sum_next = lim;
		if (sum_next < -lim)
			sum_next = -lim;
	end

	// per-wheel memory, advanced once per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
			err_sum_q  <= '0;
		end else if (ctl.upd) begin
			prev_err_q <= err;
			err_sum_q  <= sum_next[15:0];
		end
	end

	// stage 3: operands with the sum from before this tick
	always_ff @(posedge clk) begin
		if (ctl.en3) begin
			err_s3  <= err;
			diff_s3 <= err_diff;
			sum_s3  <= err_sum_q;
		end
	end

	// stage 4: gain products
	always_ff @(posedge clk) begin
		if (ctl.en4) begin
			p_s4 <= $signed({1'b0, cfg.prop_gain}) * err_s3;
			d_s4 <= $signed({1'b0, cfg.deriv_gain}) * diff_s3;
			i_s4 <= $signed({1'b0, cfg.integ_gain}) * sum_s3;
		end
	end

	// sum, divide by 256 toward zero
	always_comb begin
		acc      = {{3{p_s4[33]}}, p_s4} + {{2{d_s4[34]}}, d_s4} + {{4{i_s4[32]}}, i_s4};
		acc_bias = acc + (acc[36] ? 37'sd255 : 37'sd0);
		quo      = acc_bias >>> 8;
	end

	// stage 5: saturate to int16
	always_ff @(posedge clk) begin
		if (ctl.en5) begin
			if (quo > 37'sd32767)
				drive <= 16'sh7FFF;
			else if (quo < -37'sd32768)
				drive <= 16'sh8000;
			else
				drive <= quo[15:0];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/mecanum_chassis_speed_loop.sv */
// A word taken into stage 1 moves through stages 2 to 4 and shows its drives once it is in stage 5.
// Throughput: one word per cycle while drive.ready holds; the five-stage pipeline with one PID lane
// per wheel, each with its own three multipliers, sets that figure.
// Reset: arst_n clears the pipeline valid bits, each wheel's previous error
// and error sum, and loads the gain, limit and spin registers with defaults.
// ----------------------------------------------------------------------------
// mecanum_chassis_speed_loop: remote sticks to four PID wheel drives
// Stick scaling and mixing feed four parallel PID lanes; the output stage
// merges the lane drives into one word.
// ----------------------------------------------------------------------------
`default_nettype none

module mecanum_chassis_speed_loop (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	mcsl_in_if.sink                              tick,
	mcsl_out_if.source                           drive,
	input  wire logic                            wr_en,
	input  wire logic [mcsl_pkg::CfgIndexW-1:0]  wr_index,
	input  wire logic [mcsl_pkg::CfgDataW-1:0]   wr_data
);

	mcsl_pkg::pid_cfg_t  cfg_q;
	logic [11:0]         spin_rate_q;
	mcsl_pkg::ctl_t      ctl;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	mcsl_pkg::target_t   target [mcsl_pkg::WheelCount];
	mcsl_pkg::speed_t    speed  [mcsl_pkg::WheelCount];
	logic signed [15:0]  lane_drive [mcsl_pkg::WheelCount];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain   <= mcsl_pkg::PropGainRst;
			cfg_q.integ_gain  <= mcsl_pkg::IntegGainRst;
			cfg_q.deriv_gain  <= mcsl_pkg::DerivGainRst;
			cfg_q.integ_limit <= mcsl_pkg::IntegLimitRst;
			spin_rate_q       <= mcsl_pkg::SpinRateRst;
		end else if (wr_en) begin
			unique case (wr_index)
				mcsl_pkg::RegPropGain:   cfg_q.prop_gain   <= wr_data;
				mcsl_pkg::RegIntegGain:  cfg_q.integ_gain  <= wr_data;
				mcsl_pkg::RegDerivGain:  cfg_q.deriv_gain  <= wr_data;
				mcsl_pkg::RegIntegLimit: cfg_q.integ_limit <= wr_data[14:0];
				mcsl_pkg::RegSpinRate:   spin_rate_q       <= wr_data[11:0];
				default: ;
			endcase
		end
	end

	// per-stage ready: a stage loads when empty or when it drains
	always_comb begin
		rdy5 = !v_s5 || drive.ready;
		rdy4 = !v_s4 || rdy5;
		rdy3 = !v_s3 || rdy4;
		rdy2 = !v_s2 || rdy3;
		rdy1 = !v_s1 || rdy2;
		ctl.en1 = rdy1;
		ctl.en2 = rdy2;
		ctl.en3 = rdy3;
		ctl.en4 = rdy4;
		ctl.en5 = rdy5;
		ctl.upd = rdy3 && v_s2;
	end

	assign tick.ready = rdy1;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= tick.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	mcsl_mixer u_mixer (
		.clk           (clk),
		.ctl           (ctl),
		.spin_rate     (spin_rate_q),
		.turn_stick    (tick.turn_stick),
		.strafe_stick  (tick.strafe_stick),
		.forward_stick (tick.forward_stick),
		.rotate_switch (tick.rotate_switch),
		.target        (target)
	);

	assign speed[0] = tick.speed_one;
	assign speed[1] = tick.speed_two;
	assign speed[2] = tick.speed_three;
	assign speed[3] = tick.speed_four;

	// one PID lane per wheel
	for (genvar w = 0; w < mcsl_pkg::WheelCount; w++) begin : g_lane
		mcsl_pid_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.cfg    (cfg_q),
			.speed  (speed[w]),
			.target (target[w]),
			.drive  (lane_drive[w])
		);
	end

	// merge the lane drives into the output word
	assign drive.valid       = v_s5;
	assign drive.drive_one   = lane_drive[0];
	assign drive.drive_two   = lane_drive[1];
	assign drive.drive_three = lane_drive[2];
	assign drive.drive_four  = lane_drive[3];

endmodule

`default_nettype wire
